FILE: hdl/tmcw_pkg.sv
// Package for the text-mode console writer.
// Holds the default screen geometry, the character codes, the field widths
// and the controller state type. It depends on nothing else.
package tmcw_pkg;

	localparam int unsigned COLUMNS_DEF = 80;
	localparam int unsigned ROWS_DEF    = 24;

	localparam int unsigned CODE_W   = 9;
	localparam int unsigned INDEX_W  = 11;
	localparam int unsigned CURPOS_W = 11;
	localparam int unsigned CELL_W   = 16;
	localparam int unsigned ATTR_W   = 8;

	localparam logic [CODE_W-1:0] CODE_NEWLINE   = 9'h00A;
	localparam logic [CODE_W-1:0] CODE_BACKSPACE = 9'h100;
	localparam logic [CODE_W-1:0] CODE_LEFT      = 9'h0E4;
	localparam logic [CODE_W-1:0] CODE_RIGHT     = 9'h0E5;

	localparam logic [7:0]        CHAR_SPACE = 8'h20;
	localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;

	localparam logic OP_PUT  = 1'b0;
	localparam logic OP_READ = 1'b1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_SCROLL,
		ST_HOLD
	} state_t;

endpackage

FILE: hdl/text_mode_console_writer.sv
// Text-mode console writer: cursor plus a COLUMNS x ROWS store of 16-bit cells.
// A put without scroll loads the output register at its accepting edge if the register
// is free, else it waits in the hold state; a read passes through one registered RAM read
// first; a put that scrolls moves the rows up and zeroes the last, one cell per cycle through the RAM port.
// Throughput: one put per cycle while the output register is free; a read or a scroll holds the input
// off until its result is loaded. Reset: attribute 7, cursor 0, then a clearing pass over every cell.
module text_mode_console_writer #(
	parameter int unsigned COLUMNS = tmcw_pkg::COLUMNS_DEF,
	parameter int unsigned ROWS    = tmcw_pkg::ROWS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// input requests
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            operation,
	input  logic [tmcw_pkg::CODE_W-1:0]     char_code,
	input  logic [tmcw_pkg::INDEX_W-1:0]    cell_index,
	// result requests
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [tmcw_pkg::CURPOS_W-1:0]   cursor_position,
	output logic [tmcw_pkg::CELL_W-1:0]     cell_value,
	output logic                            scrolled,
	// attribute register write
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [tmcw_pkg::ATTR_W-1:0]     cfg_data
);

	localparam int unsigned CELLS = COLUMNS * ROWS;
	localparam int unsigned ADR_W = $clog2(CELLS);      // RAM address / cursor
	localparam int unsigned POS_W = $clog2(CELLS + 1);  // cursor before scroll
	localparam int unsigned SRC_W = ADR_W + 1;          // scan source address
	localparam int unsigned ROW_W = $clog2(ROWS + 1);
	localparam int unsigned COL_W = $clog2(COLUMNS);
	localparam int unsigned VAL_W = tmcw_pkg::CELL_W;

	// ------------------------------------------------------------------
	// Registers
	// ------------------------------------------------------------------
	tmcw_pkg::state_t state_q, state_d;

	logic [tmcw_pkg::ATTR_W-1:0] attr_q;
	logic [ADR_W-1:0]            cursor_q;
	logic [ROW_W-1:0]            row_q;
	logic [COL_W-1:0]            col_q;
	logic [ADR_W-1:0]            cnt_q, cnt_d;     // clear and scroll sweep

	logic                        oob_q;            // read index beyond the screen

	// pending result, held while the output register is occupied or a scroll runs
	logic [ADR_W-1:0]            pend_cursor_q;
	logic [VAL_W-1:0]            pend_value_q;
	logic                        pend_scrolled_q;

	// output register
	logic                        out_valid_q;
	logic [ADR_W-1:0]            out_cursor_q;
	logic [VAL_W-1:0]            out_value_q;
	logic                        out_scrolled_q;

	// scroll write-back stage: writes in the cycle after the read of its source cell
	logic                        scan_wr_s1;
	logic [ADR_W-1:0]            scan_addr_s1;
	logic                        scan_src_s1;

	// ------------------------------------------------------------------
	// Combinational signals
	// ------------------------------------------------------------------
	logic                        accept;
	logic                        slot_free;
	logic                        out_load, pend_load;
	logic [ADR_W-1:0]            res_cursor;
	logic [VAL_W-1:0]            res_value;
	logic                        res_scrolled;

	logic                        ram_wr_en, ram_rd_en;
	logic [ADR_W-1:0]            ram_wr_addr, ram_rd_addr;
	logic [VAL_W-1:0]            ram_wr_data, ram_rd_data;

	logic [POS_W-1:0]            pos_w, adv_pos, npos;
	logic [ROW_W-1:0]            adv_row, nrow, fin_row;
	logic [COL_W-1:0]            adv_col, ncol;
	logic [ADR_W-1:0]            fin_pos;
	logic                        put_write, wrap, blank;

	logic [31:0]                 idx_wide;
	logic                        idx_in_range;
	logic [SRC_W-1:0]            scan_src;
	logic                        scan_src_ok;
	logic [31:0]                 out_cur_wide;

	assign accept    = in_valid && in_ready;
	assign in_ready  = (state_q == tmcw_pkg::ST_IDLE);
	assign cfg_ready = 1'b1;
	assign slot_free = !out_valid_q || out_ready;

	assign idx_wide     = 32'(cell_index);
	assign idx_in_range = idx_wide < 32'(CELLS);

	// source cell of the scroll step: one row below the cell being written
	assign scan_src    = SRC_W'(cnt_q) + SRC_W'(COLUMNS);
	assign scan_src_ok = scan_src < SRC_W'(CELLS);

	// ------------------------------------------------------------------
	// Cursor arithmetic for a put (row and column kept beside the linear
	// cursor, so no division is needed)
	// ------------------------------------------------------------------
	always_comb begin
		pos_w   = POS_W'(cursor_q);
		adv_pos = pos_w + POS_W'(1);
		if (col_q == COL_W'(COLUMNS - 1)) begin
			adv_col = '0;
			adv_row = row_q + ROW_W'(1);
		end else begin
			adv_col = col_q + COL_W'(1);
			adv_row = row_q;
		end

		npos      = pos_w;
		nrow      = row_q;
		ncol      = col_q;
		put_write = 1'b0;
		case (char_code)
			tmcw_pkg::CODE_NEWLINE: begin
				npos = pos_w - POS_W'(col_q) + POS_W'(COLUMNS);
				nrow = row_q + ROW_W'(1);
				ncol = '0;
			end
			tmcw_pkg::CODE_BACKSPACE, tmcw_pkg::CODE_LEFT: begin
				if (cursor_q != '0) begin
					npos = pos_w - POS_W'(1);
					if (col_q == '0) begin
						ncol = COL_W'(COLUMNS - 1);
						nrow = row_q - ROW_W'(1);
					end else begin
						ncol = col_q - COL_W'(1);
					end
				end
			end
			tmcw_pkg::CODE_RIGHT: begin
				// steps forward only away from the home position
				if (cursor_q != '0) begin
					npos = adv_pos;
					nrow = adv_row;
					ncol = adv_col;
				end
			end
			default: begin
				put_write = 1'b1;
				npos      = adv_pos;
				nrow      = adv_row;
				ncol      = adv_col;
			end
		endcase

		// every scrolling put lands on column 0 of the last row
		wrap    = (nrow == ROW_W'(ROWS));
		fin_pos = wrap ? ADR_W'(CELLS - COLUMNS) : npos[ADR_W-1:0];
		fin_row = wrap ? ROW_W'(ROWS - 1) : nrow;
		blank   = (char_code == tmcw_pkg::CODE_BACKSPACE);
	end

	// ------------------------------------------------------------------
	// Controller: next state, RAM port use and result routing
	// ------------------------------------------------------------------
	always_comb begin
		state_d      = state_q;
		cnt_d        = cnt_q;
		out_load     = 1'b0;
		pend_load    = 1'b0;
		res_cursor   = cursor_q;
		res_value    = '0;
		res_scrolled = 1'b0;
		ram_wr_en    = 1'b0;
		ram_wr_addr  = cursor_q;
		ram_wr_data  = {attr_q, char_code[7:0]};
		ram_rd_en    = 1'b0;
		ram_rd_addr  = idx_wide[ADR_W-1:0];

		case (state_q)
			tmcw_pkg::ST_CLEAR: begin
				// zero one cell per cycle; hold the input off until done
				ram_wr_en   = 1'b1;
				ram_wr_addr = cnt_q;
				ram_wr_data = '0;
				cnt_d       = cnt_q + ADR_W'(1);
				if (cnt_q == ADR_W'(CELLS - 1)) begin
					cnt_d   = '0;
					state_d = tmcw_pkg::ST_IDLE;
				end
			end
			tmcw_pkg::ST_IDLE: begin
				if (accept) begin
					if (operation == tmcw_pkg::OP_READ) begin
						ram_rd_en = 1'b1;
						state_d   = tmcw_pkg::ST_READ;
					end else begin
						// character cell, or blank under the cursor for backspace
						if (put_write) begin
							ram_wr_en = 1'b1;
						end else if (blank) begin
							ram_wr_en   = 1'b1;
							ram_wr_addr = fin_pos;
							ram_wr_data = {attr_q, tmcw_pkg::CHAR_SPACE};
						end
						res_cursor   = fin_pos;
						res_scrolled = wrap;
						if (wrap) begin
							pend_load = 1'b1;
							cnt_d     = '0;
							state_d   = tmcw_pkg::ST_SCROLL;
						end else if (slot_free) begin
							out_load = 1'b1;
						end else begin
							pend_load = 1'b1;
							state_d   = tmcw_pkg::ST_HOLD;
						end
					end
				end
			end
			tmcw_pkg::ST_READ: begin
				res_value = oob_q ? '0 : ram_rd_data;
				if (slot_free) begin
					out_load = 1'b1;
					state_d  = tmcw_pkg::ST_IDLE;
				end else begin
					pend_load = 1'b1;
					state_d   = tmcw_pkg::ST_HOLD;
				end
			end
			tmcw_pkg::ST_SCROLL: begin
				// read the cell one row down; the write stage stores it next cycle
				ram_rd_en   = scan_src_ok;
				ram_rd_addr = scan_src[ADR_W-1:0];
				cnt_d       = cnt_q + ADR_W'(1);
				if (cnt_q == ADR_W'(CELLS - 1)) begin
					cnt_d   = '0;
					state_d = tmcw_pkg::ST_HOLD;
				end
			end
			tmcw_pkg::ST_HOLD: begin
				res_cursor   = pend_cursor_q;
				res_value    = pend_value_q;
				res_scrolled = pend_scrolled_q;
				if (slot_free) begin
					out_load = 1'b1;
					state_d  = tmcw_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = tmcw_pkg::ST_IDLE;
			end
		endcase

		// the scroll write stage owns the write port while it is busy
		if (scan_wr_s1) begin
			ram_wr_en   = 1'b1;
			ram_wr_addr = scan_addr_s1;
			ram_wr_data = scan_src_s1 ? ram_rd_data : '0;
		end
	end

	// ------------------------------------------------------------------
	// Control registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tmcw_pkg::ST_CLEAR;
			cnt_q       <= '0;
			attr_q      <= tmcw_pkg::ATTR_RESET;
			cursor_q    <= '0;
			row_q       <= '0;
			col_q       <= '0;
			out_valid_q <= 1'b0;
			scan_wr_s1  <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (cfg_valid && cfg_ready) begin
				attr_q <= cfg_data;
			end
			if (accept && operation == tmcw_pkg::OP_PUT) begin
				cursor_q <= fin_pos;
				row_q    <= fin_row;
				col_q    <= ncol;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			scan_wr_s1 <= (state_q == tmcw_pkg::ST_SCROLL);
		end
	end

	// ------------------------------------------------------------------
	// Payload registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (accept) begin
			oob_q <= !idx_in_range;
		end
		if (pend_load) begin
			pend_cursor_q   <= res_cursor;
			pend_value_q    <= res_value;
			pend_scrolled_q <= res_scrolled;
		end
		if (out_load) begin
			out_cursor_q   <= res_cursor;
			out_value_q    <= res_value;
			out_scrolled_q <= res_scrolled;
		end
		scan_addr_s1 <= cnt_q;
		scan_src_s1  <= scan_src_ok;
	end

	tmcw_ram #(
		.WIDTH (VAL_W),
		.DEPTH (CELLS)
	) u_cells (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	// drop cursor bits above the port width
	assign out_cur_wide    = 32'(out_cursor_q);
	assign cursor_position = out_cur_wide[tmcw_pkg::CURPOS_W-1:0];
	assign cell_value      = out_value_q;
	assign scrolled        = out_scrolled_q;
	assign out_valid       = out_valid_q;

endmodule

FILE: hdl/tmcw_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Holds the screen cells of the console writer; depends on no package.
module tmcw_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 1920
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule
